// ----- rtl/vtrd_pkg.sv -----
// Shared types, constants and helper functions for the radix digit string converter.
// No dependencies; vtrd_step and value_to_radix_digit_string in rtl/ import this package.

package vtrd_pkg;

    // Default values for the top-level parameters
    localparam int INT_BITS_DEF        = 32;
    localparam int FRAC_BITS_DEF       = 32;
    localparam int MAX_FRAC_DIGITS_DEF = 16;

    // Fixed widths of the channel fields
    localparam int IN_W    = 32;
    localparam int RADIX_W = 2;
    localparam int CHAR_W  = 7;
    localparam int DIGIT_W = 4;

    // x / 10 == (x * RECIP10) >> RECIP10_SHIFT, exact for every 32-bit x
    localparam logic [IN_W-1:0] RECIP10       = 32'hCCCC_CCCD;
    localparam int              RECIP10_SHIFT = 35;

    // ASCII codes
    localparam logic [CHAR_W-1:0] CHAR_ZERO     = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_A_MINUS_TEN = 7'h37;
    localparam logic [CHAR_W-1:0] CHAR_DOT      = 7'h2E;

    typedef enum logic [RADIX_W-1:0] {
        RADIX_2  = 2'd0,
        RADIX_8  = 2'd1,
        RADIX_10 = 2'd2,
        RADIX_16 = 2'd3
    } radix_code_t;

    // Control from the sequencer to the shared digit unit
    typedef struct packed {
        logic mul_en;     // load the reciprocal product register
        logic frac_mode;  // select the fraction digit on the digit output
    } step_ctl_t;

    function automatic logic [DIGIT_W:0] radix_of(input radix_code_t code);
        logic [DIGIT_W:0] r;
        unique case (code)
            RADIX_2:  r = 5'd2;
            RADIX_8:  r = 5'd8;
            RADIX_10: r = 5'd10;
            RADIX_16: r = 5'd16;
            default:  r = 5'd2;
        endcase
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] ascii_of(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < 4'd10) begin
            c = CHAR_ZERO + {3'b000, d};
        end else begin
            c = CHAR_A_MINUS_TEN + {3'b000, d};
        end
        return c;
    endfunction

endpackage

// ----- rtl/vtrd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; width and depth come from parameters.

module vtrd_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/vtrd_step.sv -----
// Shared digit unit: one division-by-radix step on the integer quotient or one
// multiply-by-radix step on the fraction. Depends on vtrd_pkg.

module vtrd_step #(
    parameter int INT_W     = 32,
    parameter int FRAC_BITS = 32
) (
    input  logic                        aclk,
    input  vtrd_pkg::step_ctl_t         ctl,
    input  vtrd_pkg::radix_code_t       radix_code,
    input  logic [INT_W-1:0]            quotient,
    input  logic [FRAC_BITS-1:0]        fraction,
    output logic [vtrd_pkg::DIGIT_W-1:0] digit,
    output logic [INT_W-1:0]            quotient_next,
    output logic [FRAC_BITS-1:0]        fraction_next
);

    import vtrd_pkg::*;

    localparam int PROD_W = 2 * IN_W;
    localparam int Q10_W  = PROD_W - RECIP10_SHIFT;
    localparam int P_W    = FRAC_BITS + DIGIT_W;

    logic [IN_W-1:0]    q_ext;
    logic [PROD_W-1:0]  prod_full;
    logic [PROD_W-1:0]  prod_reg;
    logic [Q10_W-1:0]   q10;
    logic [IN_W-1:0]    q10_x10;
    logic [IN_W-1:0]    rem10;
    logic [DIGIT_W-1:0] int_digit;
    logic [P_W-1:0]     p;
    logic [DIGIT_W-1:0] frac_raw;
    logic [DIGIT_W-1:0] frac_digit;
    logic [DIGIT_W:0]   radix;

    assign q_ext     = IN_W'(quotient);
    assign prod_full = q_ext * RECIP10;

    // Decimal registers the reciprocal product in the cycle before the digit step
    always_ff @(posedge aclk) begin
        if (ctl.mul_en) begin
            prod_reg <= prod_full;
        end
    end

    assign q10     = prod_reg[PROD_W-1:RECIP10_SHIFT];
    assign q10_x10 = {q10, 3'b000} + IN_W'({q10, 1'b0});
    assign rem10   = q_ext - q10_x10;
    assign radix   = radix_of(radix_code);

    always_comb begin
        unique case (radix_code)
            RADIX_2: begin
                int_digit     = {3'b000, quotient[0]};
                quotient_next = quotient >> 1;
                p             = {3'b000, fraction, 1'b0};
            end
            RADIX_8: begin
                int_digit     = {1'b0, quotient[2:0]};
                quotient_next = quotient >> 3;
                p             = {1'b0, fraction, 3'b000};
            end
            RADIX_10: begin
                int_digit     = rem10[DIGIT_W-1:0];
                quotient_next = INT_W'(q10);
                p             = {1'b0, fraction, 3'b000} + {3'b000, fraction, 1'b0};
            end
            RADIX_16: begin
                int_digit     = quotient[3:0];
                quotient_next = quotient >> 4;
                p             = {fraction, 4'b0000};
            end
            default: begin
                int_digit     = '0;
                quotient_next = '0;
                p             = '0;
            end
        endcase
    end

    // Clamp the fraction digit to radix-1; the low bits stay the remainder
    assign frac_raw      = p[P_W-1:FRAC_BITS];
    assign frac_digit    = ({1'b0, frac_raw} >= radix) ? DIGIT_W'(radix - 5'd1) : frac_raw;
    assign fraction_next = p[FRAC_BITS-1:0];

    assign digit = ctl.frac_mode ? frac_digit : int_digit;

endmodule

// ----- rtl/value_to_radix_digit_string.sv -----
// Converts a non-negative fixed-point value (32-bit integer part, Q0.32 fraction)
// to an ASCII string in base 2, 8, 10 or 16, one character per output beat, most
// significant first, with is_last on the final character and truncated set there
// when fraction bits remain after MAX_FRAC_DIGITS digits. One item is converted at
// a time and s_ready is low while it runs. The shared digit unit produces one
// integer digit per step (base 10 first spends an S_MUL state on its reciprocal
// multiply), and each integer character costs a digit-store read (S_RD) and an
// emit state (S_EMIT_INT); fraction digits are produced as they are emitted.
// Depends on vtrd_pkg, vtrd_step and vtrd_ram.

module value_to_radix_digit_string #(
    parameter int INT_BITS        = vtrd_pkg::INT_BITS_DEF,
    parameter int FRAC_BITS       = vtrd_pkg::FRAC_BITS_DEF,
    parameter int MAX_FRAC_DIGITS = vtrd_pkg::MAX_FRAC_DIGITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [vtrd_pkg::IN_W-1:0]     s_integer_part,
    input  logic [vtrd_pkg::IN_W-1:0]     s_fraction_part,
    input  logic [vtrd_pkg::RADIX_W-1:0]  s_radix_code,
    input  logic                          s_with_fraction,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [vtrd_pkg::CHAR_W-1:0]   m_character,
    output logic                          m_is_last,
    output logic                          m_truncated
);

    import vtrd_pkg::*;

    localparam int INT_W       = (INT_BITS < IN_W) ? INT_BITS : IN_W;
    localparam int STORE_DEPTH = (INT_BITS > IN_W) ? INT_BITS : IN_W;
    localparam int AW          = $clog2(STORE_DEPTH);
    localparam int FW2         = FRAC_BITS + IN_W;
    localparam int FCW         = $clog2(MAX_FRAC_DIGITS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_RD,
        S_EMIT_INT,
        S_DOT,
        S_FRAC
    } state_t;

    state_t               state_reg, state_next;
    logic [INT_W-1:0]     quotient_reg, quotient_next;
    logic [FRAC_BITS-1:0] fraction_reg, fraction_next;
    radix_code_t          radix_reg, radix_next;
    logic                 has_frac_reg, has_frac_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic [FCW-1:0]       fcnt_reg, fcnt_next;
    logic                 m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]    char_reg, char_next;
    logic                 last_reg, last_next;
    logic                 trunc_reg, trunc_next;

    logic                 s_accept;
    logic                 out_free;
    logic [FW2-1:0]       f_wide;
    logic [FRAC_BITS-1:0] f_in;
    step_ctl_t            ctl;
    logic [DIGIT_W-1:0]   digit;
    logic [INT_W-1:0]     step_q_next;
    logic [FRAC_BITS-1:0] step_f_next;
    logic                 ram_we;
    logic [DIGIT_W-1:0]   ram_rdata;
    logic                 frac_last;

    assign s_ready  = (state_reg == S_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Rescale the Q0.32 input to Q0.FRAC_BITS
    assign f_wide = {s_fraction_part, FRAC_BITS'(0)};
    assign f_in   = f_wide[FW2-1:IN_W];

    assign ctl.mul_en    = (state_reg == S_MUL);
    assign ctl.frac_mode = (state_reg == S_FRAC);
    assign ram_we        = (state_reg == S_DIV);

    assign frac_last = (fcnt_reg == FCW'(MAX_FRAC_DIGITS - 1)) || (step_f_next == '0);

    vtrd_step #(
        .INT_W     (INT_W),
        .FRAC_BITS (FRAC_BITS)
    ) u_step (
        .aclk          (aclk),
        .ctl           (ctl),
        .radix_code    (radix_reg),
        .quotient      (quotient_reg),
        .fraction      (fraction_reg),
        .digit         (digit),
        .quotient_next (step_q_next),
        .fraction_next (step_f_next)
    );

    vtrd_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (STORE_DEPTH)
    ) u_digit_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (digit),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next    = state_reg;
        quotient_next = quotient_reg;
        fraction_next = fraction_reg;
        radix_next    = radix_reg;
        has_frac_next = has_frac_reg;
        idx_next      = idx_reg;
        fcnt_next     = fcnt_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        char_next     = char_reg;
        last_next     = last_reg;
        trunc_next    = trunc_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    quotient_next = s_integer_part[INT_W-1:0];
                    fraction_next = f_in;
                    radix_next    = radix_code_t'(s_radix_code);
                    has_frac_next = s_with_fraction && (f_in != '0);
                    idx_next      = '0;
                    fcnt_next     = '0;
                    state_next    = (radix_code_t'(s_radix_code) == RADIX_10) ? S_MUL : S_DIV;
                end
            end
            S_MUL: begin
                state_next = S_DIV;
            end
            S_DIV: begin
                // Digit goes to the store at idx; a zero quotient ends the loop
                quotient_next = step_q_next;
                if (step_q_next == '0) begin
                    state_next = S_RD;
                end else begin
                    idx_next   = idx_reg + AW'(1);
                    state_next = (radix_reg == RADIX_10) ? S_MUL : S_DIV;
                end
            end
            S_RD: begin
                state_next = S_EMIT_INT;
            end
            S_EMIT_INT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    char_next    = ascii_of(ram_rdata);
                    last_next    = (idx_reg == '0) && !has_frac_reg;
                    trunc_next   = 1'b0;
                    if (idx_reg == '0) begin
                        state_next = has_frac_reg ? S_DOT : S_IDLE;
                    end else begin
                        idx_next   = idx_reg - AW'(1);
                        state_next = S_RD;
                    end
                end
            end
            S_DOT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    char_next    = CHAR_DOT;
                    last_next    = 1'b0;
                    trunc_next   = 1'b0;
                    state_next   = S_FRAC;
                end
            end
            S_FRAC: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    char_next     = ascii_of(digit);
                    last_next     = frac_last;
                    trunc_next    = frac_last && (step_f_next != '0);
                    fraction_next = step_f_next;
                    fcnt_next     = fcnt_reg + FCW'(1);
                    if (frac_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        quotient_reg <= quotient_next;
        fraction_reg <= fraction_next;
        radix_reg    <= radix_next;
        has_frac_reg <= has_frac_next;
        idx_reg      <= idx_next;
        fcnt_reg     <= fcnt_next;
        char_reg     <= char_next;
        last_reg     <= last_next;
        trunc_reg    <= trunc_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_character = char_reg;
    assign m_is_last   = last_reg;
    assign m_truncated = trunc_reg;

endmodule

// ----- test/value_to_radix_digit_string_tb.sv -----
// Self-checking testbench for value_to_radix_digit_string: drives values with random
// bursts, predicts each digit string in place and compares every output beat in order.
// Depends on vtrd_pkg and the RTL of the converter.

module value_to_radix_digit_string_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vtrd_pkg::*;

    localparam int               FRAC_DIGIT_LIMIT = 16;
    localparam logic [CHAR_W-1:0] LETTER_A        = 7'h41;
    localparam int               MAX_REPORTS      = 10;
    localparam int               SETTLE_CYCLES    = 150;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              trunc;
    } char_beat_t;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_COIN,
        READY_ONE_IN_FOUR,
        READY_SPARSE
    } ready_mode_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic              s_valid         = 1'b0;
    logic              s_ready;
    logic [IN_W-1:0]   s_integer_part  = '0;
    logic [IN_W-1:0]   s_fraction_part = '0;
    logic [RADIX_W-1:0] s_radix_code   = '0;
    logic              s_with_fraction = 1'b0;
    logic              m_valid;
    logic              m_ready         = 1'b0;
    logic [CHAR_W-1:0] m_character;
    logic              m_is_last;
    logic              m_truncated;

    char_beat_t  pending_chars[$];
    int          mismatch_count = 0;
    int          burst_left     = 0;
    bit          gaps_enabled   = 1'b1;
    ready_mode_t ready_mode     = READY_ALWAYS;
    int          ready_left     = 0;

    value_to_radix_digit_string u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_integer_part  (s_integer_part),
        .s_fraction_part (s_fraction_part),
        .s_radix_code    (s_radix_code),
        .s_with_fraction (s_with_fraction),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_character     (m_character),
        .m_is_last       (m_is_last),
        .m_truncated     (m_truncated)
    );

    always #2 aclk = ~aclk;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        if (d < 4'd10) begin
            return CHAR_ZERO + CHAR_W'(d);
        end
        return LETTER_A + CHAR_W'(d) - CHAR_W'(10);
    endfunction

    // Queue the characters one value converts to, most significant first.
    function automatic void predict_digit_string(input logic [IN_W-1:0] ival,
                                                 input logic [IN_W-1:0] fval,
                                                 input radix_code_t     code,
                                                 input logic            with_frac);
        logic [IN_W-1:0]    quot;
        logic [IN_W-1:0]    rest;
        logic [63:0]        prod;
        logic [31:0]        digit;
        logic [31:0]        base;
        logic [DIGIT_W-1:0] int_digits[32];
        logic [DIGIT_W-1:0] frac_digits[FRAC_DIGIT_LIMIT];
        int                 n_int;
        int                 n_frac;
        bit                 has_frac;
        bit                 trunc;
        case (code)
            RADIX_2:  base = 2;
            RADIX_8:  base = 8;
            RADIX_10: base = 10;
            default:  base = 16;
        endcase
        quot  = ival;
        n_int = 0;
        if (quot == '0) begin
            int_digits[0] = '0;
            n_int = 1;
        end else begin
            while (quot != '0) begin
                int_digits[n_int] = DIGIT_W'(quot % base);
                quot = quot / base;
                n_int++;
            end
        end
        has_frac = with_frac && (fval != '0);
        for (int i = n_int - 1; i >= 0; i--) begin
            pending_chars.push_back('{digit_char(int_digits[i]), (i == 0) && !has_frac, 1'b0});
        end
        if (has_frac) begin
            rest   = fval;
            n_frac = 0;
            while (rest != '0 && n_frac < FRAC_DIGIT_LIMIT) begin
                prod  = 64'(rest) * 64'(base);
                digit = prod[63:32];
                if (digit >= base) begin
                    digit = base - 1;
                end
                rest = prod[31:0];
                frac_digits[n_frac] = DIGIT_W'(digit);
                n_frac++;
            end
            trunc = (rest != '0);
            pending_chars.push_back('{CHAR_DOT, 1'b0, 1'b0});
            for (int i = 0; i < n_frac; i++) begin
                pending_chars.push_back('{digit_char(frac_digits[i]), i == n_frac - 1,
                                          (i == n_frac - 1) && trunc});
            end
        end
    endfunction

    // Predict on every accepted input beat, then check every output beat.
    always @(posedge aclk) begin : check_beats
        char_beat_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_digit_string(s_integer_part, s_fraction_part,
                                     radix_code_t'(s_radix_code), s_with_fraction);
            end
            if (m_valid && m_ready) begin
                if (pending_chars.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("unexpected beat: char=%h last=%b trunc=%b",
                                 m_character, m_is_last, m_truncated);
                    end
                end else begin
                    want = pending_chars.pop_front();
                    if (want.ch !== m_character || want.last !== m_is_last ||
                        want.trunc !== m_truncated) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS) begin
                            $display({"mismatch: char exp %h got %h, last exp %b got %b,",
                                      " trunc exp %b got %b"},
                                     want.ch, m_character, want.last, m_is_last,
                                     want.trunc, m_truncated);
                        end
                    end
                end
            end
        end
    end

    // Receiver back-pressure, switching between patterns of its own.
    always @(posedge aclk) begin
        if (ready_left == 0) begin
            ready_mode <= ready_mode_t'($urandom_range(0, 3));
            ready_left <= $urandom_range(20, 120);
        end else begin
            ready_left <= ready_left - 1;
        end
        case (ready_mode)
            READY_ALWAYS:      m_ready <= 1'b1;
            READY_COIN:        m_ready <= 1'($urandom_range(0, 1));
            READY_ONE_IN_FOUR: m_ready <= (ready_left % 4 == 0);
            default:           m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Present one value and hold it until accepted; valid stays high when no gap follows.
    task automatic push_value(input logic [IN_W-1:0] ival, input logic [IN_W-1:0] fval,
                              input radix_code_t code, input logic with_frac);
        int gap;
        s_valid         <= 1'b1;
        s_integer_part  <= ival;
        s_fraction_part <= fval;
        s_radix_code    <= code;
        s_with_fraction <= with_frac;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 8);
            gap = 0;
            if (gaps_enabled && $urandom_range(0, 3) != 0) begin
                gap = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 120);
            end
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic wait_for_string_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_chars.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [IN_W-1:0] shaped_word();
        case ($urandom_range(0, 4))
            0:       return $urandom >> $urandom_range(0, 31);
            1:       return $urandom << $urandom_range(0, 31);
            2:       return ($urandom_range(0, 1) == 0) ? '0 : '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_corner_values();
        for (int r = 0; r < 4; r++) begin
            push_value('0, '0, radix_code_t'(r), 1'b0);
            push_value('1, '1, radix_code_t'(r), 1'b1);
            push_value('0, 32'h0000_0001, radix_code_t'(r), 1'b1);
        end
        push_value(32'd1, 32'h8000_0000, RADIX_10, 1'b0);
        push_value('0, '0, RADIX_16, 1'b1);
        push_value(32'd10, 32'h8000_0000, RADIX_10, 1'b1);
        push_value(32'h8000_0000, 32'h4000_0000, RADIX_2, 1'b1);
        push_value(32'h5555_5555, 32'hAAAA_AAAA, RADIX_8, 1'b1);
    endtask

    // Sixteen binary digits exactly, with and without a leftover remainder, then hex and decimal fractions.
    task automatic test_fraction_limits();
        push_value('0, 32'h0001_0000, RADIX_2, 1'b1);
        push_value('0, 32'h0001_8000, RADIX_2, 1'b1);
        push_value(32'd7, 32'h0000_0100, RADIX_16, 1'b1);
        push_value(32'd99, 32'hFFFF_FFFF, RADIX_10, 1'b1);
    endtask

    task automatic test_random_values(input int count);
        for (int i = 0; i < count; i++) begin
            push_value(shaped_word(), shaped_word(), radix_code_t'($urandom_range(0, 3)),
                       ($urandom_range(0, 3) != 0));
        end
    endtask

    task automatic test_back_to_back();
        gaps_enabled = 1'b0;
        test_random_values(15);
        gaps_enabled = 1'b1;
    endtask

    // Hold the sender until every character has come out, then resume.
    task automatic test_drain_pause();
        test_random_values(5);
        wait_for_string_drain();
        test_random_values(5);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_corner_values();
        test_fraction_limits();
        test_random_values(40);
        test_drain_pause();
        test_back_to_back();
        test_random_values(30);
        wait_for_string_drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_chars.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
